// ===== rtl/core/gea_pkg.sv =====
// Package for the gated exponential average block: widths, register indexes,
// reset values and the divider status type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gea_pkg;

   localparam int SAMPLE_W = 24;
   localparam int MEAN_W   = 32;
   localparam int COEF_W   = 16;
   localparam int LIMIT_W  = 24;
   localparam int MUL_B_W  = COEF_W + 1;
   localparam int PROD_W   = MEAN_W + MUL_B_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int DIV_CNT_W  = 5;

   localparam logic [CSR_IDX_W-1:0] REG_ALPHA        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_THRESH       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_IGNORE_LIMIT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DIVIDE_MODE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_INIT_MEAN    = 3'd4;

   localparam logic [COEF_W-1:0] ALPHA_RESET  = 16'd655;
   localparam logic [COEF_W-1:0] THRESH_RESET = 16'd768;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

// ===== rtl/core/gea_mul.sv =====
// Shared registered multiplier, 32 x 17 bits; the product appears in the cycle after issue.
// Depends on gea_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gea_mul (
   input  wire logic                          clock,
   input  wire logic [gea_pkg::MEAN_W-1:0]    mul_a,
   input  wire logic [gea_pkg::MUL_B_W-1:0]   mul_b,
   output logic      [gea_pkg::PROD_W-1:0]    product
);

   logic [gea_pkg::PROD_W-1:0] prod_ff;
   logic [gea_pkg::PROD_W-1:0] prod_in;

   assign prod_in = gea_pkg::PROD_W'(mul_a) * gea_pkg::PROD_W'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign product = prod_ff;

endmodule

`default_nettype wire

// ===== rtl/core/gea_div.sv =====
// Restoring bit-serial divider: floor(sample * 2^24 / mean), saturated to 32 bits.
// One quotient bit per cycle; saturating cases set done straight from start, with an all-ones quotient.
// Depends on gea_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gea_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [gea_pkg::SAMPLE_W-1:0]  sample,
   input  wire logic [gea_pkg::MEAN_W-1:0]    mean,
   output gea_pkg::div_status_type            status,
   output logic      [gea_pkg::MEAN_W-1:0]    quotient
);

   logic [gea_pkg::MEAN_W-1:0]    rem_ff,  rem_in;
   logic [gea_pkg::MEAN_W-1:0]    qsh_ff,  qsh_in;
   logic [gea_pkg::DIV_CNT_W-1:0] cnt_ff,  cnt_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [gea_pkg::MEAN_W:0]      trial;
   logic [gea_pkg::MEAN_W:0]      diff;
   logic                          ge;
   logic                          sat;

   // quotient would not fit 32 bits (covers a zero mean too)
   assign sat   = {16'd0, sample} >= {mean, 8'd0};
   assign trial = {rem_ff, qsh_ff[gea_pkg::MEAN_W-1]};
   assign diff  = trial - {1'b0, mean};
   assign ge    = trial >= {1'b0, mean};

   always_comb begin
      rem_in  = rem_ff;
      qsh_in  = qsh_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         if (sat) begin
            qsh_in  = '1;
            done_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            rem_in  = {16'd0, sample[23:8]};
            qsh_in  = {sample[7:0], 24'd0};
            cnt_in  = '1;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in = ge ? diff[gea_pkg::MEAN_W-1:0] : trial[gea_pkg::MEAN_W-1:0];
         qsh_in = {qsh_ff[gea_pkg::MEAN_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      qsh_ff <= qsh_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = qsh_ff;

endmodule

`default_nettype wire

// ===== rtl/core/gated_exponential_average.sv =====
// Top level of the gated exponential average: registers, sequencer and output stage.
// Depends on gea_pkg, gea_mul and gea_div.
//
//   channel  dir  fields (lowest bit first)
//   req_     in   tdata: sample[23:0]          tuser: restart
//   rsp_     out  tdata: result_value[31:0]    tuser: sample_gated
//   csr_     in   wen, index[2:0], wdata[31:0]
//
// Per item: S_LIMIT, S_TEST, S_KEEP and S_TAKE for a quiet sample, S_OUT, S_DIV in
// divide mode for the 32-step serial divider, S_DONE; three multiplies per quiet item.
// The block takes no new item until the current one sits in the output register.
// A waiting result does not stall the next item until that one is finished.
// Reset is synchronous, clears the mean and the gate count and loads register defaults.
`timescale 1ns / 1ps
`default_nettype none

module gated_exponential_average (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [gea_pkg::SAMPLE_W-1:0]      req_tdata,   // sample
   input  wire logic                              req_tuser,   // restart
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic      [gea_pkg::MEAN_W-1:0]        rsp_tdata,   // result_value
   output logic                                   rsp_tuser,   // sample_gated
   input  wire logic                              csr_wen,
   input  wire logic [gea_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [gea_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_LIMIT = 3'd1;
   localparam logic [2:0] S_TEST  = 3'd2;
   localparam logic [2:0] S_KEEP  = 3'd3;
   localparam logic [2:0] S_TAKE  = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;
   localparam logic [2:0] S_DIV   = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   logic [gea_pkg::COEF_W-1:0]   alpha_ff,  alpha_in;
   logic [gea_pkg::COEF_W-1:0]   thresh_ff, thresh_in;
   logic [gea_pkg::LIMIT_W-1:0]  limit_ff,  limit_in;
   logic                         divmode_ff, divmode_in;
   logic [gea_pkg::MEAN_W-1:0]   init_ff,   init_in;

   logic [2:0]                   state_ff,  state_in;
   logic [gea_pkg::MEAN_W-1:0]   mean_ff,   mean_in;
   logic [gea_pkg::LIMIT_W-1:0]  count_ff,  count_in;
   logic [gea_pkg::SAMPLE_W-1:0] sample_ff, sample_in;
   logic                         gated_ff,  gated_in;
   logic [gea_pkg::MEAN_W-1:0]   res_ff,    res_in;
   logic [gea_pkg::PROD_W:0]     acc_ff,    acc_in;
   logic                         rvalid_ff, rvalid_in;
   logic [gea_pkg::MEAN_W-1:0]   rdata_ff,  rdata_in;
   logic                         ruser_ff,  ruser_in;

   logic [gea_pkg::MEAN_W-1:0]   mul_a;
   logic [gea_pkg::MUL_B_W-1:0]  mul_b;
   logic [gea_pkg::PROD_W-1:0]   product;
   logic                         div_start;
   gea_pkg::div_status_type      div_status;
   logic [gea_pkg::MEAN_W-1:0]   quotient;
   logic                         req_xfer;
   logic                         rsp_load;
   logic                         quiet;
   logic [gea_pkg::PROD_W:0]     blend_sum;

   gea_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .product (product)
   );

   gea_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .sample   (sample_ff),
      .mean     (mean_ff),
      .status   (div_status),
      .quotient (quotient)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_load   = (state_ff == S_DONE) && (!rvalid_ff || rsp_tready);
   assign quiet      = {8'd0, sample_ff, 16'd0} <= product[47:0];
   assign div_start  = (state_ff == S_OUT) && divmode_ff;
   assign blend_sum  = acc_ff + {1'b0, product};

   always_comb begin
      case (state_ff)
         S_LIMIT: begin
            mul_a = mean_ff;
            mul_b = {1'b0, thresh_ff};
         end
         S_TEST: begin
            mul_a = mean_ff;
            mul_b = 17'h10000 - {1'b0, alpha_ff};
         end
         S_KEEP: begin
            mul_a = {sample_ff, 8'd0};
            mul_b = {1'b0, alpha_ff};
         end
         default: begin
            mul_a = mean_ff;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      alpha_in   = alpha_ff;
      thresh_in  = thresh_ff;
      limit_in   = limit_ff;
      divmode_in = divmode_ff;
      init_in    = init_ff;
      if (csr_wen) begin
         case (csr_index)
            gea_pkg::REG_ALPHA:        alpha_in   = csr_wdata[15:0];
            gea_pkg::REG_THRESH:       thresh_in  = csr_wdata[15:0];
            gea_pkg::REG_IGNORE_LIMIT: limit_in   = csr_wdata[23:0];
            gea_pkg::REG_DIVIDE_MODE:  divmode_in = csr_wdata[0];
            gea_pkg::REG_INIT_MEAN:    init_in    = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in  = state_ff;
      mean_in   = mean_ff;
      count_in  = count_ff;
      sample_in = sample_ff;
      gated_in  = gated_ff;
      res_in    = res_ff;
      acc_in    = acc_ff;
      rvalid_in = rvalid_ff;
      rdata_in  = rdata_ff;
      ruser_in  = ruser_ff;
      if (rvalid_ff && rsp_tready) begin
         rvalid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               sample_in = req_tdata;
               gated_in  = 1'b0;
               if (req_tuser) begin
                  mean_in  = init_ff;
                  count_in = '0;
               end
               state_in = S_LIMIT;
            end
         end
         S_LIMIT: state_in = S_TEST;
         S_TEST: begin
            if (quiet) begin
               state_in = S_KEEP;
            end else if (count_ff < limit_ff) begin
               count_in = count_ff + 1'b1;
               gated_in = 1'b1;
               state_in = S_OUT;
            end else begin
               count_in = '0;
               mean_in  = {sample_ff, 8'd0};
               state_in = S_OUT;
            end
         end
         S_KEEP: begin
            acc_in   = {1'b0, product} + 50'd32768;
            state_in = S_TAKE;
         end
         S_TAKE: begin
            mean_in  = blend_sum[47:16];
            count_in = '0;
            state_in = S_OUT;
         end
         S_OUT: begin
            res_in   = mean_ff;
            state_in = divmode_ff ? S_DIV : S_DONE;
         end
         S_DIV: begin
            if (div_status.done) begin
               res_in   = quotient;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               rvalid_in = 1'b1;
               rdata_in  = res_ff;
               ruser_in  = gated_ff;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      gated_ff  <= gated_in;
      res_ff    <= res_in;
      acc_ff    <= acc_in;
      rdata_ff  <= rdata_in;
      ruser_ff  <= ruser_in;
      if (reset) begin
         alpha_ff   <= gea_pkg::ALPHA_RESET;
         thresh_ff  <= gea_pkg::THRESH_RESET;
         limit_ff   <= '0;
         divmode_ff <= 1'b0;
         init_ff    <= '0;
         state_ff   <= S_IDLE;
         mean_ff    <= '0;
         count_ff   <= '0;
         rvalid_ff  <= 1'b0;
      end else begin
         alpha_ff   <= alpha_in;
         thresh_ff  <= thresh_in;
         limit_ff   <= limit_in;
         divmode_ff <= divmode_in;
         init_ff    <= init_in;
         state_ff   <= state_in;
         mean_ff    <= mean_in;
         count_ff   <= count_in;
         rvalid_ff  <= rvalid_in;
      end
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = rdata_ff;
   assign rsp_tuser  = ruser_ff;

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> state_ff == S_DIV)
      else $error("divider finished outside its wait state");

   a_div_busy_in_div: assert property (@(posedge clock) disable iff (reset)
      div_status.busy |-> state_ff == S_DIV)
      else $error("divider busy outside its wait state");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> state_ff == S_LIMIT)
      else $error("accepted transfer did not start the sequence");

   a_gated_counts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && gated_ff) |-> count_ff != '0)
      else $error("gated sample with a clear gate count");

   a_mean_out: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && !divmode_ff) |=> rsp_tdata == $past(mean_ff))
      else $error("mean mode result differs from the running mean");

endmodule

`default_nettype wire
